@@ design/cga_pkg.sv @@
// ----------------------------------------------------------------------------
// cga_pkg: shared constants for the clamped gravity attraction unit
// Distance clamp bounds, register reset value and datapath widths.
// ----------------------------------------------------------------------------
package cga_pkg;

  localparam int unsigned DIST_MIN_Q8 = 1280;
  localparam int unsigned DIST_MAX_Q8 = 6400;
  localparam logic [15:0] GAIN_RESET  = 16'd1638;

  // square root of sq * 2^14
  localparam int SQRT_IN_W   = 64;
  localparam int SQRT_ROOT_W = 32;

  // strength divider: (s*16 + dc2/2) / dc2
  localparam int STR_NUM_W = 53;
  localparam int STR_DEN_W = 26;
  localparam int STR_QUO_W = 32;

  // component divider: (|d|*2^7*strength + mag/2) / mag
  localparam int CMP_NUM_W = 64;
  localparam int CMP_DEN_W = 32;
  localparam int CMP_QUO_W = 33;

endpackage

@@ design/cga_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// cga_sqrt_pipe: pipelined integer square root
// One result bit per stage, restoring digit recurrence, with sideband data.
// ----------------------------------------------------------------------------
module cga_sqrt_pipe #(
  parameter int IN_W   = cga_pkg::SQRT_IN_W,
  parameter int ROOT_W = cga_pkg::SQRT_ROOT_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   in_val,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);
  import cga_pkg::*;

  logic [IN_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int I = ROOT_W - 1 - k;
    logic [IN_W-1:0]   src_rem;
    logic [ROOT_W-1:0] src_root;
    logic [SIDE_W-1:0] src_side;
    logic              src_vld;
    logic [IN_W-1:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign src_rem  = in_val;
      assign src_root = '0;
      assign src_side = in_side;
      assign src_vld  = in_vld;
    end else begin : g_next
      assign src_rem  = rem_q[k-1];
      assign src_root = root_q[k-1];
      assign src_side = side_q[k-1];
      assign src_vld  = vld_q[k-1];
    end

    // (2*q + 2^i) * 2^i, root bits below i are still zero
    assign trial = (IN_W'(src_root) << (I + 1)) | (IN_W'(1) << (2 * I));
    assign take  = (src_rem >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? (src_rem - trial) : src_rem;
        root_q[k] <= take ? (src_root | (ROOT_W'(1) << I)) : src_root;
        side_q[k] <= src_side;
      end
    end
  end

  assign out_vld  = vld_q[ROOT_W-1];
  assign out_root = root_q[ROOT_W-1];
  assign out_side = side_q[ROOT_W-1];

endmodule

@@ design/cga_div_pipe.sv @@
// ----------------------------------------------------------------------------
// cga_div_pipe: pipelined unsigned divider
// Input register, then one restoring quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module cga_div_pipe #(
  parameter int NUM_W  = cga_pkg::STR_NUM_W,
  parameter int DEN_W  = cga_pkg::STR_DEN_W,
  parameter int QUO_W  = cga_pkg::STR_QUO_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);
  import cga_pkg::*;

  localparam int CMP_W = DEN_W + QUO_W;

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [SIDE_W-1:0] side_r;
  logic              vld_r;

  logic [NUM_W-1:0]  rem_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic              vld_q  [QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= in_num;
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int J = QUO_W - 1 - k;
    logic [NUM_W-1:0]  src_rem;
    logic [DEN_W-1:0]  src_den;
    logic [QUO_W-1:0]  src_quo;
    logic [SIDE_W-1:0] src_side;
    logic              src_vld;
    logic [CMP_W-1:0]  trial;
    logic [CMP_W-1:0]  rem_ext;
    logic              take;

    if (k == 0) begin : g_first
      assign src_rem  = num_r;
      assign src_den  = den_r;
      assign src_quo  = '0;
      assign src_side = side_r;
      assign src_vld  = vld_r;
    end else begin : g_next
      assign src_rem  = rem_q[k-1];
      assign src_den  = den_q[k-1];
      assign src_quo  = quo_q[k-1];
      assign src_side = side_q[k-1];
      assign src_vld  = vld_q[k-1];
    end

    assign trial   = CMP_W'(src_den) << J;
    assign rem_ext = CMP_W'(src_rem);
    assign take    = (rem_ext >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? NUM_W'(rem_ext - trial) : src_rem;
        den_q[k]  <= src_den;
        quo_q[k]  <= take ? (src_quo | (QUO_W'(1) << J)) : src_quo;
        side_q[k] <= src_side;
      end
    end
  end

  assign out_vld  = vld_q[QUO_W-1];
  assign out_quo  = quo_q[QUO_W-1];
  assign out_side = side_q[QUO_W-1];

endmodule

@@ design/clamped_gravity_attraction_unit.sv @@
// ----------------------------------------------------------------------------
// clamped_gravity_attraction_unit: pairwise 2-D gravity force, fixed point
// Force on this body from the other, distance clamped to 5..25 pixels in the
// force law, components saturated to signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_ready carries one body pair per word
//   output channel out_valid/out_ready carries force_x, force_y, saturated
//   cfg_wr_en/cfg_wr_data write gravity_gain (Q4.12); write only while idle
// Pipeline: an accepted input word passes the 32-stage square root, then the
//   33- and 34-stage dividers, before its result appears.
// Throughput: one word per cycle unless the output stalls; every stage is a plain pipeline register.
// Reset (rst, synchronous): all valid bits clear, gravity_gain = 0.4.
// Stall: when the output register holds a word that is not taken, the whole
//   pipeline holds in place and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module clamped_gravity_attraction_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] own_x,
  input  logic signed [23:0] own_y,
  input  logic signed [23:0] other_x,
  input  logic signed [23:0] other_y,
  input  logic [15:0]        own_mass,
  input  logic [15:0]        other_mass,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic               saturated
);
  import cga_pkg::*;

  typedef struct packed {
    logic        zero;
    logic        sx;
    logic        sy;
    logic [24:0] adx;
    logic [24:0] ady;
    logic [47:0] s;
  } sqrt_side_t;

  typedef struct packed {
    logic        zero;
    logic        sx;
    logic        sy;
    logic [24:0] adx;
    logic [24:0] ady;
    logic [31:0] mag;
  } str_side_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } cmp_side_t;

  logic        en;
  logic [15:0] gain;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain <= cfg_wr_data;
    end
  end

  // p0: differences
  logic               v0;
  logic signed [24:0] dx0, dy0;
  logic [15:0]        m1_0, m2_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx0  <= 25'(own_x) - 25'(other_x);
      dy0  <= 25'(own_y) - 25'(other_y);
      m1_0 <= own_mass;
      m2_0 <= other_mass;
    end
  end

  // p1: magnitudes, gain * m1
  logic        v1;
  logic        sx1, sy1;
  logic [24:0] adx1, ady1;
  logic [31:0] gm1;
  logic [15:0] m2_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1  <= dx0[24];
      sy1  <= dy0[24];
      adx1 <= dx0[24] ? 25'(-dx0) : 25'(dx0);
      ady1 <= dy0[24] ? 25'(-dy0) : 25'(dy0);
      gm1  <= {16'b0, gain} * {16'b0, m1_0};
      m2_1 <= m2_0;
    end
  end

  // p2: squares, strength numerator
  logic        v2;
  logic        sx2, sy2;
  logic [24:0] adx2, ady2;
  logic [49:0] qx2, qy2;
  logic [47:0] s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx2  <= sx1;
      sy2  <= sy1;
      adx2 <= adx1;
      ady2 <= ady1;
      qx2  <= {25'b0, adx1} * {25'b0, adx1};
      qy2  <= {25'b0, ady1} * {25'b0, ady1};
      s2   <= {16'b0, gm1} * {32'b0, m2_1};
    end
  end

  // p3: squared length
  logic        v3;
  logic        sx3, sy3;
  logic [24:0] adx3, ady3;
  logic [49:0] sq3;
  logic [47:0] s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx3  <= sx2;
      sy3  <= sy2;
      adx3 <= adx2;
      ady3 <= ady2;
      sq3  <= qx2 + qy2;
      s3   <= s2;
    end
  end

  // length in Q.15; its top 25 bits are also floor(sqrt(sq)) in Q.8
  sqrt_side_t        sq_side_in, sq_side_out;
  logic              v_sq;
  logic [31:0]       mag_sq;

  assign sq_side_in = '{zero: (sq3 == '0), sx: sx3, sy: sy3,
                        adx: adx3, ady: ady3, s: s3};

  cga_sqrt_pipe #(
    .IN_W   (SQRT_IN_W),
    .ROOT_W (SQRT_ROOT_W),
    .SIDE_W ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v3),
    .in_val   ({sq3, 14'b0}),
    .in_side  (sq_side_in),
    .out_vld  (v_sq),
    .out_root (mag_sq),
    .out_side (sq_side_out)
  );

  // p4: clamp distance
  logic        v4;
  sqrt_side_t  side4;
  logic [31:0] mag4;
  logic [12:0] dc4;
  logic [24:0] dist_sq;

  assign dist_sq = mag_sq[31:7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= sq_side_out;
      mag4  <= mag_sq;
      if (dist_sq < 25'(DIST_MIN_Q8)) begin
        dc4 <= 13'(DIST_MIN_Q8);
      end else if (dist_sq > 25'(DIST_MAX_Q8)) begin
        dc4 <= 13'(DIST_MAX_Q8);
      end else begin
        dc4 <= dist_sq[12:0];
      end
    end
  end

  // p5: squared clamped distance
  logic        v5;
  sqrt_side_t  side5;
  logic [31:0] mag5;
  logic [25:0] dc2_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5 <= side4;
      mag5  <= mag4;
      dc2_5 <= {13'b0, dc4} * {13'b0, dc4};
    end
  end

  // strength = round(s * 16 / dc^2)
  str_side_t         st_side_in, st_side_out;
  logic              v_st;
  logic [31:0]       strength;
  logic [STR_NUM_W-1:0] st_num;

  assign st_num     = STR_NUM_W'({side5.s, 4'b0}) + STR_NUM_W'(dc2_5[25:1]);
  assign st_side_in = '{zero: side5.zero, sx: side5.sx, sy: side5.sy,
                        adx: side5.adx, ady: side5.ady, mag: mag5};

  cga_div_pipe #(
    .NUM_W  (STR_NUM_W),
    .DEN_W  (STR_DEN_W),
    .QUO_W  (STR_QUO_W),
    .SIDE_W ($bits(str_side_t))
  ) u_div_str (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v5),
    .in_num   (st_num),
    .in_den   (dc2_5),
    .in_side  (st_side_in),
    .out_vld  (v_st),
    .out_quo  (strength),
    .out_side (st_side_out)
  );

  // p6: scaled components
  logic        v6;
  logic        zero6, sx6, sy6;
  logic [31:0] mag6;
  logic [63:0] px6, py6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v_st;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero6 <= st_side_out.zero;
      sx6   <= st_side_out.sx;
      sy6   <= st_side_out.sy;
      mag6  <= st_side_out.mag;
      px6   <= {32'b0, st_side_out.adx, 7'b0} * {32'b0, strength};
      py6   <= {32'b0, st_side_out.ady, 7'b0} * {32'b0, strength};
    end
  end

  // per-component rounded division by the length
  cmp_side_t            cx_side_out, cy_side_out;
  logic                 v_cx, v_cy;
  logic [CMP_QUO_W-1:0] mx, my;
  logic [CMP_NUM_W-1:0] nx, ny;

  assign nx = px6 + {33'b0, mag6[31:1]};
  assign ny = py6 + {33'b0, mag6[31:1]};

  cga_div_pipe #(
    .NUM_W  (CMP_NUM_W),
    .DEN_W  (CMP_DEN_W),
    .QUO_W  (CMP_QUO_W),
    .SIDE_W ($bits(cmp_side_t))
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v6),
    .in_num   (nx),
    .in_den   (mag6),
    .in_side  (cmp_side_t'{zero: zero6, neg: sx6}),
    .out_vld  (v_cx),
    .out_quo  (mx),
    .out_side (cx_side_out)
  );

  cga_div_pipe #(
    .NUM_W  (CMP_NUM_W),
    .DEN_W  (CMP_DEN_W),
    .QUO_W  (CMP_QUO_W),
    .SIDE_W ($bits(cmp_side_t))
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v6),
    .in_num   (ny),
    .in_den   (mag6),
    .in_side  (cmp_side_t'{zero: zero6, neg: sy6}),
    .out_vld  (v_cy),
    .out_quo  (my),
    .out_side (cy_side_out)
  );

  // saturate and apply sign
  logic [31:0] fx_next, fy_next;
  logic        satx, saty;

  always_comb begin
    satx = 1'b0;
    if (cx_side_out.neg) begin
      if (mx > 33'h080000000) begin
        satx    = 1'b1;
        fx_next = 32'h80000000;
      end else begin
        fx_next = 32'(-mx[31:0]);
      end
    end else begin
      if (mx > 33'h07fffffff) begin
        satx    = 1'b1;
        fx_next = 32'h7fffffff;
      end else begin
        fx_next = mx[31:0];
      end
    end
  end

  always_comb begin
    saty = 1'b0;
    if (cy_side_out.neg) begin
      if (my > 33'h080000000) begin
        saty    = 1'b1;
        fy_next = 32'h80000000;
      end else begin
        fy_next = 32'(-my[31:0]);
      end
    end else begin
      if (my > 33'h07fffffff) begin
        saty    = 1'b1;
        fy_next = 32'h7fffffff;
      end else begin
        fy_next = my[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_cx && v_cy;
    end
  end

  // zero difference gives no force
  always_ff @(posedge clk) begin
    if (en) begin
      if (cx_side_out.zero) begin
        force_x   <= '0;
        force_y   <= '0;
        saturated <= 1'b0;
      end else begin
        force_x   <= fx_next;
        force_y   <= fy_next;
        saturated <= satx || saty;
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the clamped gravity attraction unit
// Drives body pairs with random gaps and output stalls, predicts each force
// word with a 64/128-bit integer model and compares all fields in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cga_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1500000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [23:0] ox, oy, px, py;
    logic [15:0]        m1, m2;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] fx, fy;
    logic               sat;
  } force_t;

  typedef struct {
    pair_t  p;
    bit     has_exp;
    force_t f;
  } row_t;

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  logic [15:0] cfg_wr_data = '0;
  logic in_valid = 0, in_ready;
  logic signed [23:0] own_x = '0, own_y = '0, other_x = '0, other_y = '0;
  logic [15:0] own_mass = '0, other_mass = '0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] force_x, force_y;
  logic saturated;

  clamped_gravity_attraction_unit u_dut (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_ready,
    .own_x, .own_y, .other_x, .other_y, .own_mass, .other_mass,
    .out_valid, .out_ready, .force_x, .force_y, .saturated
  );

  logic [15:0] gain_q;
  force_t      pending_forces[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          sink_on = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] axis_force(logic signed [63:0] d, logic [63:0] strength,
                                              logic [63:0] mag, ref bit sat);
    logic [127:0] num, m;
    logic [63:0]  ad;
    ad  = d < 0 ? -d : d;
    num = ({64'd0, ad} << 7) * strength;
    m   = (num + (mag >> 1)) / mag;
    if (d >= 0) begin
      if (m > 128'h7FFF_FFFF) begin
        sat = 1;
        m = 128'h7FFF_FFFF;
      end
      return m[31:0];
    end
    if (m > 128'h8000_0000) begin
      sat = 1;
      m = 128'h8000_0000;
    end
    return -m[31:0];
  endfunction

  function automatic force_t gravity_force(pair_t p);
    logic signed [63:0] dx, dy;
    logic [63:0] adx, ady, sq, dc, dc2, s, strength, mag;
    bit sat;
    force_t r;
    dx = 64'(p.ox) - 64'(p.px);
    dy = 64'(p.oy) - 64'(p.py);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    sq = adx * adx + ady * ady;
    r = '0;
    if (sq == 0) return r;
    dc = int_sqrt(sq);
    if (dc < DIST_MIN_Q8) dc = DIST_MIN_Q8;
    if (dc > DIST_MAX_Q8) dc = DIST_MAX_Q8;
    dc2 = dc * dc;
    s = 64'(gain_q) * p.m1 * p.m2;
    strength = (s * 16 + (dc2 >> 1)) / dc2;
    mag = int_sqrt(sq << 14);
    sat = 0;
    r.fx = axis_force(dx, strength, mag, sat);
    r.fy = axis_force(dy, strength, mag, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // output side: random stalls, phases of always-ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= sink_on ? 1'b1 : (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    force_t exp_f;
    if (!rst && out_valid && out_ready) begin
      if (pending_forces.size() == 0) begin
        $display("%0t unexpected word fx=%0d fy=%0d", $time, force_x, force_y);
        errors++;
      end else begin
        exp_f = pending_forces.pop_front();
        if (force_x !== exp_f.fx) begin
          $display("%0t force_x exp %0d got %0d", $time, exp_f.fx, force_x);
          errors++;
        end
        if (force_y !== exp_f.fy) begin
          $display("%0t force_y exp %0d got %0d", $time, exp_f.fy, force_y);
          errors++;
        end
        if (saturated !== exp_f.sat) begin
          $display("%0t saturated exp %0b got %0b", $time, exp_f.sat, saturated);
          errors++;
        end
      end
    end
  end

  // valid stays high from one word to the next when there is no gap
  task automatic send_pair(pair_t p, bit has_exp, force_t f);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    pending_forces.push_back(has_exp ? f : gravity_force(p));
    own_x <= p.ox; own_y <= p.oy; other_x <= p.px; other_y <= p.py;
    own_mass <= p.m1; other_mass <= p.m2;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [15:0] g);
    wait_idle();
    cfg_wr_en <= 1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en <= 0;
    gain_q = g;
  endtask

  function automatic logic signed [23:0] rand_pos(int unsigned mode);
    case (mode)
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(0, 16383))) - 24'sd8192;
      default: return $signed(24'($urandom_range(0, 2047))) - 24'sd1024;
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    pair_t p;
    int unsigned mode;
    for (int unsigned i = 0; i < n; i++) begin
      mode = $urandom_range(0, 2);
      p.ox = rand_pos(0);
      p.oy = rand_pos(0);
      // mostly near the other body, so the clamp band gets exercised
      p.px = mode == 0 ? rand_pos(0) : p.ox + rand_pos(mode);
      p.py = mode == 0 ? rand_pos(0) : p.oy + rand_pos(mode);
      if ($urandom_range(0, 31) == 0) p.py = p.oy;
      p.m1 = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom);
      p.m2 = 16'($urandom);
      send_pair(p, 0, '0);
    end
  endtask

  row_t rows[$];

  initial begin
    gain_q = GAIN_RESET;
    repeat (10) @(posedge clk);
    rst <= 0;

    // same position: zero force
    rows.push_back('{'{24'sd100, -24'sd5, 24'sd100, -24'sd5, 16'hFFFF, 16'hFFFF}, 1, '0});
    // zero mass: zero force
    rows.push_back('{'{24'sd0, 24'sd0, 24'sd2560, 24'sd0, 16'd0, 16'hFFFF}, 1, '0});
    // extreme positions, both signs
    rows.push_back('{'{24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000,
                      16'hFFFF, 16'hFFFF}, 0, '0});
    rows.push_back('{'{-24'sh800000, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
                      16'hFFFF, 16'hFFFF}, 0, '0});
    // very close: one lsb apart, clamp at minimum
    rows.push_back('{'{24'sd1, 24'sd0, 24'sd0, 24'sd0, 16'hFFFF, 16'hFFFF}, 0, '0});
    rows.push_back('{'{24'sd0, -24'sd1, 24'sd0, 24'sd0, 16'h0100, 16'h0100}, 0, '0});
    // at the clamp bounds, inside the band, and above and below it
    rows.push_back('{'{24'sd1280, 24'sd0, 24'sd0, 24'sd0, 16'h0100, 16'h0100}, 0, '0});
    rows.push_back('{'{24'sd0, 24'sd6400, 24'sd0, 24'sd0, 16'h0100, 16'h0100}, 0, '0});
    rows.push_back('{'{24'sd3000, -24'sd3000, 24'sd0, 24'sd0, 16'h1234, 16'h0800}, 0, '0});
    rows.push_back('{'{-24'sd9000, 24'sd100, 24'sd0, 24'sd0, 16'h0100, 16'h0100}, 0, '0});
    rows.push_back('{'{24'sd7, 24'sd9, 24'sd10, 24'sd5, 16'hFFFF, 16'h8000}, 0, '0});
    foreach (rows[i]) send_pair(rows[i].p, rows[i].has_exp, rows[i].f);

    // every gain write first waits for the pipeline to empty
    random_phase(150);
    write_gain(16'hFFFF);
    for (int i = 0; i < 6; i++) send_pair(rows[i + 2].p, 0, '0);
    random_phase(300);
    write_gain(16'd0);
    random_phase(100);
    write_gain(16'd1);
    random_phase(150);
    write_gain(16'($urandom));
    sink_on = 1;
    random_phase(300);
    sink_on = 0;
    write_gain(GAIN_RESET);
    random_phase(600);
    wait_idle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/cga_pkg.sv
design/cga_sqrt_pipe.sv
design/cga_div_pipe.sv
design/clamped_gravity_attraction_unit.sv
verif/tb_top.sv
